// ===== rtl/core/scpp_pkg.sv =====
// Shared types, codes and constants of the serial command packet parser.
// No dependencies; used by every module under rtl/core.
package scpp_pkg;

	localparam int PAYLOAD_DEPTH_DEF = 256;

	localparam logic [7:0] SYNC_RESET = 8'h3E;

	// byte positions within a frame, the sync byte sits at position zero
	localparam logic [8:0] POS_TARGET  = 9'd1;
	localparam logic [8:0] POS_FUNC    = 9'd2;
	localparam logic [8:0] POS_LEN     = 9'd3;
	localparam logic [8:0] POS_PAYLOAD = 9'd4;

	localparam logic [7:0] TARGET_MIN = 8'd1;
	localparam logic [7:0] TARGET_MAX = 8'd3;
	localparam logic [7:0] FUNC_MIN   = 8'd1;
	localparam logic [7:0] FUNC_MAX   = 8'd6;

	localparam logic [1:0] TARGET_ARM = 2'd1;
	localparam logic [2:0] FUNC_ANGLE = 3'd2;
	localparam logic [2:0] FUNC_VEL   = 3'd5;
	localparam logic [2:0] FUNC_PERM  = 3'd6;

	localparam logic [7:0] LEN_ANGLE = 8'd48;
	localparam logic [7:0] LEN_VEL   = 8'd2;
	localparam logic [7:0] LEN_PERM  = 8'd1;

	localparam logic [3:0] LAST_JOINT = 4'd11;
	localparam logic [7:0] PERM_MAX   = 8'd1;

	typedef enum logic [2:0] {
		KIND_ANGLE    = 3'd0,
		KIND_VEL      = 3'd1,
		KIND_PERM     = 3'd2,
		KIND_MOTOR    = 3'd3,
		KIND_CHECKSUM = 3'd4,
		KIND_BADTGT   = 3'd5,
		KIND_BADFUNC  = 3'd6,
		KIND_BADPERM  = 3'd7
	} kind_t;

	typedef enum logic {
		ST_RUN  = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	// payload memory access request: byte write, 32-bit word read
	typedef struct packed {
		logic       we;
		logic [7:0] widx;
		logic [7:0] wdata;
		logic       re;
		logic [3:0] rword;
	} mem_req_t;

endpackage

// ===== rtl/core/serial_command_packet_parser_top.sv =====
// Serial command packet parser, top level. A byte that ends a frame with an
// immediate result (error, motor enable) shows it in the cycle after its
// transaction; velocity and permission results pass through the registered read
// of the payload memory and then the output register; an angle frame gives twelve
// results, one per cycle while the output is not stalled, through the single
// one-word read port of the payload memory. Throughput: one byte per cycle while
// the output is free; input holds while results are emitted. Reset clears all
// control state asynchronously; the payload memory is not cleared, so no clearing
// pass follows reset. Depends on scpp_pkg, scpp_parser and scpp_payload_mem.
module serial_command_packet_parser_top #(
	parameter int PAYLOAD_DEPTH = scpp_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: sync byte value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// received bytes: [7:0] rx_byte
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// results: [2:0] kind, [6:3] joint_index, [38:7] payload_value, [39] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	scpp_pkg::mem_req_t mem_req;
	logic [31:0]        mem_rdata;
	logic [2:0]         kind;
	logic [3:0]         joint_index;
	logic [31:0]        payload_value;

	// Decode frames, write payload bytes and sequence the results.
	scpp_parser #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.rx_byte      (s_tdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.kind         (kind),
		.joint_index  (joint_index),
		.payload_value(payload_value),
		.last         (m_tlast),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

	// Hold the payload; a read returns one 32-bit word from a registered read port.
	scpp_payload_mem #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rdata(mem_rdata)
	);

	// Pack the result fields, lowest field first, padded to whole bytes.
	assign m_tdata = {1'b0, payload_value, joint_index, kind};

endmodule

// ===== rtl/core/scpp_payload_mem.sv =====
// Payload buffer: 32-bit words with byte-lane writes and a registered read.
// Depends on scpp_pkg (mem_req_t).
module scpp_payload_mem #(
	parameter int PAYLOAD_DEPTH = scpp_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic               clk,
	input  scpp_pkg::mem_req_t req,
	output logic [31:0]        rdata
);

	localparam int WORDS = (PAYLOAD_DEPTH + 3) / 4;
	localparam int AW    = $clog2(WORDS);

	logic [31:0] mem_q [WORDS];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[AW'(req.widx[7:2])][{req.widx[1:0], 3'b000} +: 8] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[AW'(req.rword)];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/scpp_parser.sv =====
// Frame parser: byte position tracking, checksum, payload writes and the
// result sequencer that reads the payload memory back. Depends on scpp_pkg.
module scpp_parser #(
	parameter int PAYLOAD_DEPTH = scpp_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [3:0]         joint_index,
	output logic [31:0]        payload_value,
	output logic               last,
	output scpp_pkg::mem_req_t mem_req,
	input  logic [31:0]        mem_rdata
);

	scpp_pkg::state_t state_q, state_d;
	scpp_pkg::kind_t  mode_q, mode_d;

	logic [7:0] sync_q;
	logic       in_frame_q, in_frame_d;
	logic [8:0] pos_q, pos_d;
	logic [1:0] target_q, target_d;
	logic [2:0] func_q, func_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic [3:0] joint_q, joint_d;

	logic            out_valid_q;
	scpp_pkg::kind_t out_kind_q;
	logic [3:0]      out_joint_q;
	logic [31:0]     out_value_q;
	logic            out_last_q;

	logic            out_free, acc, opening, active;
	logic [8:0]      pos, idx;
	logic            start_emit, emit_load, emit_done;
	logic            load, load_last;
	scpp_pkg::kind_t load_kind;
	logic [3:0]      load_joint;
	logic [31:0]     load_value;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scpp_pkg::ST_RUN: begin
				if (start_emit) begin
					state_d = scpp_pkg::ST_EMIT;
				end
			end
			scpp_pkg::ST_EMIT: begin
				if (emit_load && emit_done) begin
					state_d = scpp_pkg::ST_RUN;
				end
			end
			default: state_d = scpp_pkg::ST_RUN;
		endcase
	end

	// frame decode, memory requests and result loading
	always_comb begin
		in_ready   = (state_q == scpp_pkg::ST_RUN) && out_free;
		acc        = in_valid && in_ready;
		opening    = !in_frame_q && (rx_byte == sync_q);
		active     = acc && (in_frame_q || opening);
		pos        = opening ? 9'd0 : pos_q;
		idx        = pos - scpp_pkg::POS_PAYLOAD;

		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		target_d   = target_q;
		func_d     = func_q;
		len_d      = len_q;
		sum_d      = sum_q;
		mode_d     = mode_q;
		joint_d    = joint_q;

		start_emit = 1'b0;
		mem_req    = '0;
		load       = 1'b0;
		load_last  = 1'b1;
		load_kind  = scpp_pkg::KIND_CHECKSUM;
		load_joint = 4'd0;
		load_value = 32'd0;

		emit_load  = (state_q == scpp_pkg::ST_EMIT) && out_free;
		emit_done  = (mode_q != scpp_pkg::KIND_ANGLE) || (joint_q == scpp_pkg::LAST_JOINT);

		if (active) begin
			in_frame_d = 1'b1;
			pos_d      = pos + 9'd1;
			if (pos == scpp_pkg::POS_TARGET) begin
				if (rx_byte >= scpp_pkg::TARGET_MIN && rx_byte <= scpp_pkg::TARGET_MAX) begin
					target_d = rx_byte[1:0];
				end else begin
					target_d   = 2'd0;
					in_frame_d = 1'b0;
					load       = 1'b1;
					load_kind  = scpp_pkg::KIND_BADTGT;
				end
			end else if (pos == scpp_pkg::POS_FUNC) begin
				if (rx_byte >= scpp_pkg::FUNC_MIN && rx_byte <= scpp_pkg::FUNC_MAX) begin
					func_d = rx_byte[2:0];
				end else begin
					func_d     = 3'd0;
					in_frame_d = 1'b0;
					load       = 1'b1;
					load_kind  = scpp_pkg::KIND_BADFUNC;
				end
			end else if (pos == scpp_pkg::POS_LEN) begin
				len_d = rx_byte;
				sum_d = 8'd0;
			end else if (pos >= scpp_pkg::POS_PAYLOAD) begin
				if (len_q == 8'd0) begin
					// empty frame: the byte after the length closes it
					in_frame_d = 1'b0;
					if (target_q == scpp_pkg::TARGET_ARM && func_q == scpp_pkg::FUNC_PERM) begin
						load       = 1'b1;
						load_kind  = scpp_pkg::KIND_MOTOR;
						load_value = 32'd1;
					end
				end else if (idx < {1'b0, len_q}) begin
					sum_d = sum_q + rx_byte;
					if (idx < 9'(PAYLOAD_DEPTH)) begin
						mem_req.we    = 1'b1;
						mem_req.widx  = idx[7:0];
						mem_req.wdata = rx_byte;
					end
				end else begin
					// check byte
					in_frame_d = 1'b0;
					if (rx_byte != sum_q) begin
						load      = 1'b1;
						load_kind = scpp_pkg::KIND_CHECKSUM;
					end else if (target_q == scpp_pkg::TARGET_ARM) begin
						if (func_q == scpp_pkg::FUNC_ANGLE && len_q == scpp_pkg::LEN_ANGLE) begin
							start_emit = 1'b1;
							mode_d     = scpp_pkg::KIND_ANGLE;
						end else if (func_q == scpp_pkg::FUNC_VEL && len_q == scpp_pkg::LEN_VEL) begin
							start_emit = 1'b1;
							mode_d     = scpp_pkg::KIND_VEL;
						end else if (func_q == scpp_pkg::FUNC_PERM &&
							len_q == scpp_pkg::LEN_PERM) begin
							start_emit = 1'b1;
							mode_d     = scpp_pkg::KIND_PERM;
						end
					end
					if (start_emit) begin
						joint_d       = 4'd0;
						mem_req.re    = 1'b1;
						mem_req.rword = 4'd0;
					end
				end
			end
		end

		if (emit_load) begin
			load      = 1'b1;
			load_last = emit_done;
			case (mode_q)
				scpp_pkg::KIND_ANGLE: begin
					load_kind  = scpp_pkg::KIND_ANGLE;
					load_joint = joint_q;
					load_value = mem_rdata;
				end
				scpp_pkg::KIND_VEL: begin
					load_kind  = scpp_pkg::KIND_VEL;
					load_value = {16'd0, mem_rdata[15:0]};
				end
				default: begin
					if (mem_rdata[7:0] <= scpp_pkg::PERM_MAX) begin
						load_kind  = scpp_pkg::KIND_PERM;
						load_value = {31'd0, mem_rdata[0]};
					end else begin
						load_kind  = scpp_pkg::KIND_BADPERM;
					end
				end
			endcase
			if (!emit_done) begin
				// fetch the next angle word while this one goes out
				joint_d       = joint_q + 4'd1;
				mem_req.re    = 1'b1;
				mem_req.rword = joint_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scpp_pkg::ST_RUN;
			mode_q      <= scpp_pkg::KIND_ANGLE;
			sync_q      <= scpp_pkg::SYNC_RESET;
			in_frame_q  <= 1'b0;
			pos_q       <= 9'd0;
			target_q    <= 2'd0;
			func_q      <= 3'd0;
			len_q       <= 8'd0;
			sum_q       <= 8'd0;
			joint_q     <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			target_q   <= target_d;
			func_q     <= func_d;
			len_q      <= len_d;
			sum_q      <= sum_d;
			joint_q    <= joint_d;
			if (cfg_valid) begin
				sync_q <= cfg_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q  <= load_kind;
			out_joint_q <= load_joint;
			out_value_q <= load_value;
			out_last_q  <= load_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign joint_index   = out_joint_q;
	assign payload_value = out_value_q;
	assign last          = out_last_q;

endmodule
